[src/kf2_pkg.sv]
// kf2_pkg: shared types, constants and arithmetic helpers for the two-state kalman filter
package kf2_pkg;

   localparam int FRAC_BITS = 8;
   localparam int OPND_W    = 32;
   localparam int PROD_W    = 2 * OPND_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int Y_W       = 26;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_W     = 32 + 2 * FRAC_BITS;
   localparam int QUO_W     = 31;
   localparam int DIV_CNT_W = 5;
   localparam int LP_SHIFT  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TRANSITION    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVATION   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE    = 3'd4;

   localparam logic [63:0] TRANSITION_RESET  = 64'h0100_0000_0000_0100;
   localparam logic [63:0] DRIVE_RESET       = 64'h0;
   localparam logic [31:0] OBSERVATION_RESET = 32'h0000_0100;
   localparam logic [63:0] PROCESS_RESET     = 64'h0;
   localparam logic [15:0] MEAS_NOISE_RESET  = 16'h0100;

   localparam logic signed [OPND_W-1:0] LP_KEEP = 32'sd13107;
   localparam logic signed [OPND_W-1:0] LP_TAKE = 32'sd52429;

   typedef struct packed {
      logic               measurement_present;
      logic signed [15:0] drive_first;
      logic signed [15:0] drive_second;
      logic signed [15:0] measured_value;
   } kf2_req_type;

   typedef struct packed {
      logic signed [15:0] estimate_first;
      logic signed [15:0] estimate_second;
      logic signed [15:0] observed_output;
      logic               low_pass_active;
      logic               gain_suppressed;
   } kf2_rsp_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_XP, OP_AP, OP_PP, OP_PC, OP_CP, OP_SV,
      OP_CXP, OP_KY, OP_KCP, OP_CX, OP_LP
   } kf2_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_XP, ST_AP, ST_PP, ST_PC, ST_CP, ST_SV, ST_CXP,
      ST_DIV_GO, ST_DIV_WAIT, ST_KY, ST_KCP, ST_CX, ST_LP, ST_DRAIN, ST_FINISH
   } kf2_state_type;

   typedef struct packed {
      kf2_op_type op;
      logic       i;
      logic       j;
      logic       k;
      logic       first;
      logic       last;
      logic       capture;
      logic       div_start;
      logic       div_sel;
      logic       k_clear;
      logic       load_out;
   } kf2_cmd_type;

   typedef struct packed {
      logic s_zero;
      logic div_done;
   } kf2_sts_type;

   function automatic logic signed [15:0] entry(input logic [63:0] r, input logic [1:0] idx);
      entry = signed'(r[{idx, 4'b0000} +: 16]);
   endfunction

   function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                          input int unsigned s);
      logic signed [ACC_W-1:0] half;
      half = '0;
      half[s-1] = 1'b1;
      rnd_shift = (v + half) >>> s;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > 66'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (v < -66'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > 66'sd2147483647) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage

[src/kalman_filter_2state_top.sv]
// kalman_filter_2state_top: two-state fixed-point kalman filter with low-pass fallback
//
//   channel | ports               | carries
//   --------+---------------------+----------------------------------------
//   request | req_valid/ready     | drive vector, measurement, mode bit
//   result  | rsp_valid/ready     | estimate, observed value, mode flags
//   config  | csr_write_enable    | A, B, C, R, Q by register index
//
// a beat with a measurement runs 44 products through one shared 32x32 multiplier
// and runs a radix-2 divider twice, or not at all when the sum S is zero;
// a low-pass beat uses the multiplier alone; one beat is in work at a time
// synchronous active-high reset restores the config defaults and zero state
// a result waits in the output register while rsp_ready is low; the next beat
// is taken meanwhile and holds before its load until the register frees up
module kalman_filter_2state_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kf2_pkg::kf2_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kf2_pkg::kf2_rsp_type          rsp_data,
   input  logic                          csr_write_enable,
   input  logic [kf2_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kf2_pkg::CSR_W-1:0]     csr_write_data
);
   import kf2_pkg::*;

   kf2_cmd_type cmd;
   kf2_sts_type sts;

   kf2_ctrl u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .measurement_present (req_data.measurement_present),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .cmd                 (cmd),
      .sts                 (sts)
   );

   kf2_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

[src/kf2_div.sv]
// kf2_div: radix-2 restoring divider for the gain, rounding half away from zero, saturating
module kf2_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [kf2_pkg::NUM_W-1:0] num,
   input  logic signed [31:0]            den,
   output logic                          done,
   output logic signed [31:0]            quo
);
   import kf2_pkg::*;

   logic signed [NUM_W:0] num_x;
   logic signed [32:0]    den_x;
   logic [NUM_W-1:0]      abs_n;
   logic [31:0]           abs_d;
   logic [NUM_W:0]        nsum;
   logic                  ovf;

   logic [31:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]     low_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [31:0]          ad_ff;
   logic                 neg_ff, ovf_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [32:0]          trial, diff;
   logic                 ge;

   always_comb begin
      num_x = (NUM_W+1)'(num);
      den_x = 33'(den);
      abs_n = num_x < 0 ? NUM_W'(-num_x) : NUM_W'(num_x);
      abs_d = den_x < 0 ? 32'(-den_x) : 32'(den_x);
      nsum  = (NUM_W+1)'(abs_n) + (NUM_W+1)'(abs_d >> 1);
      ovf   = 32'(nsum[NUM_W:QUO_W]) >= abs_d;
      trial = {rem_ff, low_ff[QUO_W-1]};
      diff  = trial - {1'b0, ad_ff};
      ge    = trial >= {1'b0, ad_ff};
      rem_in = ge ? diff[31:0] : trial[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(QUO_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 32'(nsum[NUM_W:QUO_W]);
         low_ff <= nsum[QUO_W-1:0];
         quo_ff <= '0;
         ad_ff  <= abs_d;
         neg_ff <= (num < 0) != (den < 0);
         ovf_ff <= ovf;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign done = done_ff;

   always_comb begin
      if (ovf_ff) begin
         quo = neg_ff ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (neg_ff) begin
         quo = -signed'({1'b0, quo_ff});
      end else begin
         quo = signed'({1'b0, quo_ff});
      end
   end

endmodule

[src/kf2_dp.sv]
// kf2_dp: datapath with config registers, shared multiply-accumulate, state and result register
module kf2_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [kf2_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kf2_pkg::CSR_W-1:0]         csr_write_data,
   input  kf2_pkg::kf2_req_type              req_data,
   output kf2_pkg::kf2_rsp_type              rsp_data,
   input  kf2_pkg::kf2_cmd_type              cmd,
   output kf2_pkg::kf2_sts_type              sts
);
   import kf2_pkg::*;

   logic [63:0] a_ff, b_ff, r_ff;
   logic [31:0] c_ff;
   logic [15:0] q_ff;

   logic signed [15:0] x_ff [2];
   logic signed [31:0] p_ff [4];
   logic signed [15:0] xp_ff [2];
   logic signed [31:0] ap_ff [4];
   logic signed [31:0] pp_ff [4];
   logic signed [31:0] pc_ff [2];
   logic signed [31:0] cp_ff [2];
   logic signed [31:0] k_ff [2];
   logic signed [31:0] s_ff;
   logic signed [Y_W-1:0] y_ff;
   logic signed [15:0] u_ff [2];
   logic signed [15:0] z_ff;
   logic signed [15:0] obs_ff;
   logic               lp_ff, sup_ff;
   kf2_rsp_type        rsp_ff;

   logic signed [OPND_W-1:0] opa, opb;
   logic signed [PROD_W-1:0] prod_ff;
   kf2_cmd_type              st_ff;
   logic signed [ACC_W-1:0]  acc_ff, sum, rnd_f, rnd_2f, rnd_lp;
   logic [63:0]              c_wide;
   logic signed [15:0]       c_i, c_k;

   logic                     div_done;
   logic signed [31:0]       div_quo;

   kf2_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (signed'({pc_ff[cmd.div_sel], (2 * FRAC_BITS)'(0)})),
      .den   (s_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      c_wide = {32'b0, c_ff};
      c_i    = entry(c_wide, {1'b0, cmd.i});
      c_k    = entry(c_wide, {1'b0, cmd.k});
      opa    = '0;
      opb    = '0;
      case (cmd.op)
         OP_XP: begin
            opa = cmd.k ? 32'(u_ff[cmd.j]) : 32'(x_ff[cmd.j]);
            opb = 32'(entry(cmd.k ? b_ff : a_ff, {cmd.i, cmd.j}));
         end
         OP_AP: begin
            opa = p_ff[{cmd.j, cmd.k}];
            opb = 32'(entry(a_ff, {cmd.i, cmd.j}));
         end
         OP_PP: begin
            opa = ap_ff[{cmd.i, cmd.k}];
            opb = 32'(entry(a_ff, {cmd.j, cmd.k}));
         end
         OP_PC: begin
            opa = pp_ff[{cmd.i, cmd.k}];
            opb = 32'(c_k);
         end
         OP_CP: begin
            opa = pp_ff[{cmd.k, cmd.i}];
            opb = 32'(c_k);
         end
         OP_SV: begin
            opa = pc_ff[cmd.i];
            opb = 32'(c_i);
         end
         OP_CXP: begin
            opa = 32'(xp_ff[cmd.i]);
            opb = 32'(c_i);
         end
         OP_KY: begin
            opa = k_ff[cmd.i];
            opb = 32'(y_ff);
         end
         OP_KCP: begin
            opa = k_ff[cmd.i];
            opb = cp_ff[cmd.j];
         end
         OP_CX: begin
            opa = 32'(x_ff[cmd.i]);
            opb = 32'(c_i);
         end
         OP_LP: begin
            opa = cmd.k ? 32'(u_ff[cmd.i]) : 32'(x_ff[cmd.i]);
            opb = cmd.k ? LP_TAKE : LP_KEEP;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      sum    = st_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      rnd_f  = rnd_shift(sum, FRAC_BITS);
      rnd_2f = rnd_shift(sum, 2 * FRAC_BITS);
      rnd_lp = rnd_shift(sum, LP_SHIFT);
   end

   // config, filter state and op tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff  <= TRANSITION_RESET;
         b_ff  <= DRIVE_RESET;
         c_ff  <= OBSERVATION_RESET;
         r_ff  <= PROCESS_RESET;
         q_ff  <= MEAS_NOISE_RESET;
         x_ff  <= '{default: '0};
         p_ff  <= '{default: '0};
         st_ff <= '0;
      end else begin
         st_ff <= cmd;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TRANSITION:    a_ff <= csr_write_data;
               CSR_DRIVE:         b_ff <= csr_write_data;
               CSR_OBSERVATION:   c_ff <= csr_write_data[31:0];
               CSR_PROCESS_NOISE: r_ff <= csr_write_data;
               CSR_MEAS_NOISE:    q_ff <= csr_write_data[15:0];
               default: ;
            endcase
         end
         if (st_ff.last) begin
            case (st_ff.op)
               OP_KY:  x_ff[st_ff.i] <= sat16(ACC_W'(xp_ff[st_ff.i]) + rnd_2f);
               OP_KCP: p_ff[{st_ff.i, st_ff.j}] <=
                          sat32(ACC_W'(pp_ff[{st_ff.i, st_ff.j}]) - rnd_2f);
               OP_LP:  x_ff[st_ff.i] <= sat16(rnd_lp);
               default: ;
            endcase
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (st_ff.op != OP_NONE) begin
         acc_ff <= sum;
      end
      if (cmd.capture) begin
         u_ff[0] <= req_data.drive_first;
         u_ff[1] <= req_data.drive_second;
         z_ff    <= req_data.measured_value;
         lp_ff   <= !req_data.measurement_present;
         sup_ff  <= 1'b0;
      end
      if (cmd.k_clear) begin
         k_ff   <= '{default: '0};
         sup_ff <= 1'b1;
      end
      if (div_done) begin
         k_ff[cmd.div_sel] <= div_quo;
      end
      if (st_ff.last) begin
         case (st_ff.op)
            OP_XP:  xp_ff[st_ff.i] <= sat16(rnd_f);
            OP_AP:  ap_ff[{st_ff.i, st_ff.k}] <= sat32(rnd_f);
            OP_PP:  pp_ff[{st_ff.i, st_ff.j}] <=
                       sat32(rnd_f + (ACC_W'(entry(r_ff, {st_ff.i, st_ff.j})) <<< FRAC_BITS));
            OP_PC:  pc_ff[st_ff.i] <= sat32(rnd_f);
            OP_CP:  cp_ff[st_ff.i] <= sat32(rnd_f);
            OP_SV:  s_ff <= sat32(rnd_f + (ACC_W'(signed'({1'b0, q_ff})) <<< FRAC_BITS));
            OP_CXP: y_ff <= Y_W'(ACC_W'(z_ff) - rnd_f);
            OP_CX:  obs_ff <= sat16(rnd_f);
            OP_LP: begin
               if (!st_ff.i) begin
                  obs_ff <= sat16(rnd_lp);
               end
            end
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         rsp_ff.estimate_first  <= x_ff[0];
         rsp_ff.estimate_second <= x_ff[1];
         rsp_ff.observed_output <= obs_ff;
         rsp_ff.low_pass_active <= lp_ff;
         rsp_ff.gain_suppressed <= sup_ff;
      end
   end

   assign rsp_data     = rsp_ff;
   assign sts.s_zero   = s_ff == '0;
   assign sts.div_done = div_done;

endmodule

[src/kf2_ctrl.sv]
// kf2_ctrl: sequencer that steps the shared multiplier and divider through one update
module kf2_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 measurement_present,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kf2_pkg::kf2_cmd_type cmd,
   input  kf2_pkg::kf2_sts_type sts
);
   import kf2_pkg::*;

   kf2_state_type state_ff, state_in, state_after;
   logic [2:0]    cnt_ff, cnt_in, cnt_last;
   logic          div_sel_ff, div_sel_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          step_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         div_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_XP, ST_AP, ST_PP:          cnt_last = 3'd7;
         ST_PC, ST_CP, ST_KCP, ST_LP:  cnt_last = 3'd3;
         ST_SV, ST_CXP, ST_KY, ST_CX:  cnt_last = 3'd1;
         default:                      cnt_last = 3'd0;
      endcase
      case (state_ff)
         ST_XP:   state_after = ST_AP;
         ST_AP:   state_after = ST_PP;
         ST_PP:   state_after = ST_PC;
         ST_PC:   state_after = ST_CP;
         ST_CP:   state_after = ST_SV;
         ST_SV:   state_after = ST_CXP;
         ST_CXP:  state_after = ST_DIV_GO;
         ST_KY:   state_after = ST_KCP;
         ST_KCP:  state_after = ST_CX;
         ST_CX:   state_after = ST_DRAIN;
         ST_LP:   state_after = ST_DRAIN;
         default: state_after = ST_IDLE;
      endcase
      step_end = cnt_ff == cnt_last;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      div_sel_in   = div_sel_ff;
      cmd          = '0;
      cmd.op       = OP_NONE;
      cmd.div_sel  = div_sel_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & !rsp_ready;

      case (state_ff)
         ST_XP: begin
            cmd.op    = OP_XP;
            cmd.i     = cnt_ff[2];
            cmd.j     = cnt_ff[0];
            cmd.k     = cnt_ff[1];
            cmd.first = cnt_ff[1:0] == 2'd0;
            cmd.last  = cnt_ff[1:0] == 2'd3;
         end
         ST_AP: begin
            cmd.op    = OP_AP;
            cmd.i     = cnt_ff[2];
            cmd.k     = cnt_ff[1];
            cmd.j     = cnt_ff[0];
            cmd.first = !cnt_ff[0];
            cmd.last  = cnt_ff[0];
         end
         ST_PP: begin
            cmd.op    = OP_PP;
            cmd.i     = cnt_ff[2];
            cmd.j     = cnt_ff[1];
            cmd.k     = cnt_ff[0];
            cmd.first = !cnt_ff[0];
            cmd.last  = cnt_ff[0];
         end
         ST_PC, ST_CP: begin
            cmd.op    = state_ff == ST_PC ? OP_PC : OP_CP;
            cmd.i     = cnt_ff[1];
            cmd.k     = cnt_ff[0];
            cmd.first = !cnt_ff[0];
            cmd.last  = cnt_ff[0];
         end
         ST_SV, ST_CXP, ST_CX: begin
            case (state_ff)
               ST_SV:   cmd.op = OP_SV;
               ST_CXP:  cmd.op = OP_CXP;
               default: cmd.op = OP_CX;
            endcase
            cmd.i     = cnt_ff[0];
            cmd.first = !cnt_ff[0];
            cmd.last  = cnt_ff[0];
            div_sel_in = 1'b0;
         end
         ST_KY: begin
            cmd.op    = OP_KY;
            cmd.i     = cnt_ff[0];
            cmd.first = 1'b1;
            cmd.last  = 1'b1;
         end
         ST_KCP: begin
            cmd.op    = OP_KCP;
            cmd.i     = cnt_ff[1];
            cmd.j     = cnt_ff[0];
            cmd.first = 1'b1;
            cmd.last  = 1'b1;
         end
         ST_LP: begin
            cmd.op    = OP_LP;
            cmd.i     = cnt_ff[1];
            cmd.k     = cnt_ff[0];
            cmd.first = !cnt_ff[0];
            cmd.last  = cnt_ff[0];
         end
         default: ;
      endcase

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = measurement_present ? ST_XP : ST_LP;
            end
         end
         ST_DIV_GO: begin
            if (sts.s_zero) begin
               cmd.k_clear = 1'b1;
               state_in    = ST_KY;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               if (!div_sel_ff) begin
                  div_sel_in = 1'b1;
                  state_in   = ST_DIV_GO;
               end else begin
                  state_in = ST_KY;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            cnt_in = step_end ? 3'd0 : cnt_ff + 3'd1;
            if (step_end) begin
               state_in = state_after;
            end
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[src/kf2_checker.sv]
// kf2_checker: port-level checks for the kalman filter, bound to the top level
module kf2_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input kf2_pkg::kf2_rsp_type rsp_data
);
   import kf2_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before accept");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled result beat changed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.low_pass_active && rsp_data.gain_suppressed))
      else $error("low-pass beat flagged as gain suppressed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a beat is in work");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind kalman_filter_2state_top kf2_checker u_kf2_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[verif/testbench.sv]
// testbench: random and directed checks of the two-state kalman filter against a predictor
module testbench;
   import kf2_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = 130;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 106;

   typedef struct {
      bit                   is_cfg;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_W-1:0]     val;
      kf2_req_type          req;
      bit                   typed;
      kf2_rsp_type          want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   kf2_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   kf2_rsp_type          rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   logic [63:0] a_reg, b_reg, r_reg;
   logic [31:0] c_reg;
   logic [15:0] q_reg;
   longint      est [2];
   longint      cov [4];

   kf2_rsp_type  pending_estimates [$];
   stim_row_type directed_rows [$];
   int           mismatches = 0;
   int           cycles = 0;
   int           stall_left = 0;
   bit           quiet = 1'b0;

   kalman_filter_2state_top dut (.*);

   always #5 clock = ~clock;

   function automatic longint coef(logic [63:0] r, int k);
      return longint'($signed(r[k*16 +: 16]));
   endfunction

   function automatic longint rsh(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint clamp32(longint v);
      return v > 64'sd2147483647 ? 64'sd2147483647 :
             (v < -64'sd2147483648 ? -64'sd2147483648 : v);
   endfunction

   function automatic longint div_near(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic kf2_rsp_type kf_update(kf2_req_type r);
      kf2_rsp_type res;
      longint u [2], c [2], xp [2], ap [4], pp [4], pc [2], cp [2], kg [2];
      longint acc, a1, a2, s, y, obs;
      bit suppressed;
      suppressed = 1'b0;
      u[0] = r.drive_first;
      u[1] = r.drive_second;
      c[0] = coef({32'b0, c_reg}, 0);
      c[1] = coef({32'b0, c_reg}, 1);
      if (!r.measurement_present) begin
         for (int i = 0; i < 2; i++)
            est[i] = clamp16(rsh(13107 * est[i] + 52429 * u[i], 16));
         obs = est[0];
      end else begin
         for (int i = 0; i < 2; i++) begin
            acc = 0;
            for (int j = 0; j < 2; j++)
               acc += coef(a_reg, i*2+j) * est[j] + coef(b_reg, i*2+j) * u[j];
            xp[i] = clamp16(rsh(acc, FRAC_BITS));
         end
         for (int i = 0; i < 2; i++)
            for (int k = 0; k < 2; k++) begin
               acc = 0;
               for (int j = 0; j < 2; j++) acc += coef(a_reg, i*2+j) * cov[j*2+k];
               ap[i*2+k] = clamp32(rsh(acc, FRAC_BITS));
            end
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               acc = 0;
               for (int k = 0; k < 2; k++) acc += ap[i*2+k] * coef(a_reg, j*2+k);
               pp[i*2+j] = clamp32(rsh(acc, FRAC_BITS) +
                                   coef(r_reg, i*2+j) * (longint'(1) <<< FRAC_BITS));
            end
         for (int i = 0; i < 2; i++) begin
            a1 = 0;
            a2 = 0;
            for (int k = 0; k < 2; k++) begin
               a1 += pp[i*2+k] * c[k];
               a2 += c[k] * pp[k*2+i];
            end
            pc[i] = clamp32(rsh(a1, FRAC_BITS));
            cp[i] = clamp32(rsh(a2, FRAC_BITS));
         end
         acc = c[0] * pc[0] + c[1] * pc[1];
         s = clamp32(rsh(acc, FRAC_BITS) + longint'(q_reg) * (longint'(1) <<< FRAC_BITS));
         kg[0] = 0;
         kg[1] = 0;
         if (s == 0) suppressed = 1'b1;
         else
            for (int i = 0; i < 2; i++)
               kg[i] = clamp32(div_near(pc[i] * (longint'(1) <<< (2*FRAC_BITS)), s));
         y = longint'(r.measured_value) - rsh(c[0] * xp[0] + c[1] * xp[1], FRAC_BITS);
         for (int i = 0; i < 2; i++) begin
            est[i] = clamp16(xp[i] + rsh(kg[i] * y, 2*FRAC_BITS));
            for (int j = 0; j < 2; j++)
               cov[i*2+j] = clamp32(pp[i*2+j] - rsh(kg[i] * cp[j], 2*FRAC_BITS));
         end
         obs = clamp16(rsh(c[0] * est[0] + c[1] * est[1], FRAC_BITS));
      end
      res.estimate_first  = est[0][15:0];
      res.estimate_second = est[1][15:0];
      res.observed_output = obs[15:0];
      res.low_pass_active = !r.measurement_present;
      res.gain_suppressed = suppressed;
      return res;
   endfunction

   task automatic settle();
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TRANSITION:    a_reg = val;
         CSR_DRIVE:         b_reg = val;
         CSR_OBSERVATION:   c_reg = val[31:0];
         CSR_PROCESS_NOISE: r_reg = val;
         CSR_MEAS_NOISE:    q_reg = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_beat(kf2_req_type r, bit typed, kf2_rsp_type want);
      kf2_rsp_type predicted;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predicted = kf_update(r);
      pending_estimates.push_back(typed ? want : predicted);
   endtask

   function automatic logic [15:0] pick_entry(int style);
      case (style)
         0: case ($urandom_range(0, 3))
               0: return 16'h7fff;
               1: return 16'h8000;
               2: return 16'h0000;
               default: return 16'h0100;
            endcase
         1: return 16'($urandom_range(0, 512) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_quad(int style);
      return {pick_entry(style), pick_entry(style), pick_entry(style), pick_entry(style)};
   endfunction

   function automatic logic [15:0] pick_field();
      if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 4095) - 2048);
      return 16'($urandom);
   endfunction

   function automatic stim_row_type cfg_row(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.idx = idx;
      row.val = val;
      return row;
   endfunction

   function automatic stim_row_type item_row(logic mp, logic [15:0] d0, logic [15:0] d1,
                                             logic [15:0] z, bit typed, kf2_rsp_type want);
      stim_row_type row;
      row = '{default: '0};
      row.req = '{mp, d0, d1, z};
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      kf2_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %h", rsp_data);
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_data.estimate_first !== want.estimate_first ||
                rsp_data.estimate_second !== want.estimate_second ||
                rsp_data.observed_output !== want.observed_output ||
                rsp_data.low_pass_active !== want.low_pass_active ||
                rsp_data.gain_suppressed !== want.gain_suppressed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   initial begin
      kf2_rsp_type none;
      kf2_req_type r;
      int style;
      none = '0;
      a_reg = TRANSITION_RESET;
      b_reg = DRIVE_RESET;
      c_reg = OBSERVATION_RESET;
      r_reg = PROCESS_RESET;
      q_reg = MEAS_NOISE_RESET;
      est = '{0, 0};
      cov = '{0, 0, 0, 0};

      directed_rows.push_back(item_row(1'b0, 16'h0, 16'h0, 16'h0, 1'b1,
                                       '{0, 0, 0, 1'b1, 1'b0}));
      directed_rows.push_back(item_row(1'b1, 16'h0, 16'h0, 16'h0, 1'b1,
                                       '{0, 0, 0, 1'b0, 1'b0}));
      directed_rows.push_back(item_row(1'b1, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, none));
      directed_rows.push_back(item_row(1'b0, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, none));
      directed_rows.push_back(item_row(1'b0, 16'h8000, 16'h8000, 16'h7fff, 1'b0, none));
      directed_rows.push_back(cfg_row(CSR_MEAS_NOISE, 64'h0));
      directed_rows.push_back(item_row(1'b1, 16'h0100, 16'h0200, 16'h0400, 1'b0, none));
      directed_rows.push_back(cfg_row(CSR_PROCESS_NOISE, 64'h8000_0000_0000_8000));
      directed_rows.push_back(item_row(1'b1, 16'h0100, 16'h0200, 16'h0400, 1'b0, none));
      directed_rows.push_back(item_row(1'b1, 16'hff00, 16'h0080, 16'hf000, 1'b0, none));
      directed_rows.push_back(cfg_row(CSR_TRANSITION, 64'h7fff_7fff_7fff_7fff));
      directed_rows.push_back(cfg_row(CSR_DRIVE, 64'h8000_8000_8000_8000));
      directed_rows.push_back(cfg_row(CSR_OBSERVATION, 64'h7fff_7fff));
      directed_rows.push_back(cfg_row(CSR_PROCESS_NOISE, 64'h7fff_7fff_7fff_7fff));
      directed_rows.push_back(cfg_row(CSR_MEAS_NOISE, 64'hffff));
      directed_rows.push_back(cfg_row(3'd5, 64'h1234_5678_9abc_def0));
      directed_rows.push_back(cfg_row(3'd7, 64'hffff_ffff_ffff_ffff));
      directed_rows.push_back(item_row(1'b1, 16'h7fff, 16'h8000, 16'h7fff, 1'b0, none));
      directed_rows.push_back(item_row(1'b1, 16'h8000, 16'h7fff, 16'h8000, 1'b0, none));
      directed_rows.push_back(item_row(1'b0, 16'h7fff, 16'h8000, 16'h0000, 1'b0, none));
      directed_rows.push_back(item_row(1'b1, 16'h0000, 16'h0000, 16'h7fff, 1'b0, none));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         if (directed_rows[n].is_cfg) begin
            req_valid <= 1'b0;
            settle();
            write_reg(directed_rows[n].idx, directed_rows[n].val);
         end else begin
            send_beat(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         settle();
         if (ph == PHASES - 1) quiet = 1'b1;
         style = (ph == PHASES - 1) ? 1 : ph % 3;
         write_reg(CSR_TRANSITION, pick_quad(style));
         write_reg(CSR_DRIVE, pick_quad(style));
         write_reg(CSR_OBSERVATION, {32'($urandom), pick_entry(style), pick_entry(style)});
         write_reg(CSR_PROCESS_NOISE, pick_quad(style));
         write_reg(CSR_MEAS_NOISE, {48'($urandom), pick_entry(style)});
         if ($urandom_range(0, 1)) write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r.measurement_present = $urandom_range(0, 2) != 0;
            r.drive_first = pick_field();
            r.drive_second = pick_field();
            r.measured_value = pick_field();
            send_beat(r, 1'b0, none);
         end
      end
      req_valid <= 1'b0;
      settle();

      if (mismatches == 0 && pending_estimates.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

[sim.f]
src/kf2_pkg.sv
src/kf2_div.sv
src/kf2_dp.sv
src/kf2_ctrl.sv
src/kalman_filter_2state_top.sv
src/kf2_checker.sv
verif/testbench.sv
